[rtl/rcct_pkg.sv]
// rcct_pkg: shared types, codes and defaults for the reference-counted cache table
// no dependencies; used by rcct_ctrl, rcct_datapath and refcounted_cache_table_unit
`default_nettype none

package rcct_pkg;

   // default table geometry
   localparam int DEF_ENTRIES  = 16;
   localparam int DEF_KEY_BITS = 32;
   localparam int DEF_REF_BITS = 8;

   // fixed port field widths
   localparam int KEY_PORT_BITS    = 32;
   localparam int STATUS_BITS      = 3;
   localparam int COUNT_PORT_BITS  = 8;
   localparam int SLOT_PORT_BITS   = 4;
   localparam int CAP_BITS         = 5;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STAT_HIT      = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_MISS     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_HELD     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_EVICT    = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_ABSENT   = 3'd5;
   localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW = 3'd6;

   // request op codes
   localparam logic OP_GET     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPD
   } rcct_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // latch request and register compare vectors
      logic lookup;   // encode hit/free slot, read count
      logic commit;   // update table and load result register
   } rcct_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy; // result register holds a transaction that is stalled
   } rcct_stat_type;

endpackage

`default_nettype wire

[rtl/rcct_ctrl.sv]
// rcct_ctrl: sequencing state machine of the cache table
// depends on rcct_pkg
`default_nettype none

module rcct_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rcct_pkg::rcct_stat_type stat,
   output rcct_pkg::rcct_cmd_type      cmd
);

   rcct_pkg::rcct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         rcct_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = rcct_pkg::ST_LOOK;
            end
         end
         rcct_pkg::ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = rcct_pkg::ST_UPD;
         end
         rcct_pkg::ST_UPD: begin
            // wait while the previous result is still stalled
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = rcct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcct_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/rcct_datapath.sv]
// rcct_datapath: key store, count memory, valid bits, occupancy and result register
// depends on rcct_pkg; driven by rcct_ctrl
`default_nettype none

module rcct_datapath #(
   parameter int ENTRIES  = rcct_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = rcct_pkg::DEF_KEY_BITS,
   parameter int REF_BITS = rcct_pkg::DEF_REF_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire rcct_pkg::rcct_cmd_type                 cmd,
   output rcct_pkg::rcct_stat_type                     stat,
   input  wire logic                                   req_op,
   input  wire logic [rcct_pkg::KEY_PORT_BITS-1:0]     req_key,
   input  wire logic                                   csr_write,
   input  wire logic [rcct_pkg::CAP_BITS-1:0]          csr_capacity_limit,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [rcct_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic [rcct_pkg::COUNT_PORT_BITS-1:0]        rsp_ref_count,
   output logic [rcct_pkg::SLOT_PORT_BITS-1:0]         rsp_slot
);

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int USED_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (USED_BITS > rcct_pkg::CAP_BITS) ? USED_BITS : rcct_pkg::CAP_BITS;
   localparam logic [CMP_BITS-1:0] ENTRIES_W = CMP_BITS'(ENTRIES);
   localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
   localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);

   // key masking to KEY_BITS
   logic [63:0]         key_wide;
   logic [KEY_BITS-1:0] key_masked;
   assign key_wide   = {32'd0, req_key};
   assign key_masked = key_wide[KEY_BITS-1:0];

   // storage
   logic [KEY_BITS-1:0] entry_key_ff  [0:ENTRIES-1];
   logic [REF_BITS-1:0] entry_refs_ff [0:ENTRIES-1];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [USED_BITS-1:0] used_ff, used_in;
   logic [rcct_pkg::CAP_BITS-1:0] cap_ff, cap_in;

   // request and lookup registers
   logic                op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [ENTRIES-1:0]  match_ff;
   logic [ENTRIES-1:0]  free_ff;
   logic                hit_found_ff, free_found_ff;
   logic [IDX_BITS-1:0] hit_idx_ff, free_idx_ff;
   logic [REF_BITS-1:0] refs_rd_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [rcct_pkg::STATUS_BITS-1:0]     rsp_status_ff;
   logic [rcct_pkg::COUNT_PORT_BITS-1:0] rsp_count_ff;
   logic [rcct_pkg::SLOT_PORT_BITS-1:0]  rsp_slot_ff;

   // parallel key compare
   logic [ENTRIES-1:0] match_vec;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (entry_key_ff[i] == key_masked);
      end
   end

   // lowest set bit
   function automatic logic [IDX_BITS-1:0] low_index(input logic [ENTRIES-1:0] vec);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_BITS'(i);
         end
      end
      return idx;
   endfunction

   logic [IDX_BITS-1:0] hit_idx_enc, free_idx_enc;
   assign hit_idx_enc  = low_index(match_ff);
   assign free_idx_enc = low_index(free_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         key_ff   <= key_masked;
         match_ff <= match_vec;
         free_ff  <= ~valid_ff;
      end
      if (cmd.lookup) begin
         hit_found_ff  <= |match_ff;
         free_found_ff <= |free_ff;
         hit_idx_ff    <= hit_idx_enc;
         free_idx_ff   <= free_idx_enc;
         refs_rd_ff    <= entry_refs_ff[hit_idx_enc];
      end
   end

   // capacity limit
   logic [CMP_BITS-1:0] cap_w, limit_w, used_w;
   assign cap_w   = CMP_BITS'(cap_ff);
   assign limit_w = (cap_w == '0 || cap_w > ENTRIES_W) ? ENTRIES_W : cap_w;
   assign used_w  = CMP_BITS'(used_ff);

   // update decision
   logic [rcct_pkg::STATUS_BITS-1:0] res_status;
   logic [REF_BITS-1:0]              res_refs;
   logic [IDX_BITS-1:0]              res_idx;
   logic                             wr_refs, wr_key, set_valid, clr_valid;
   logic [IDX_BITS-1:0]              wr_idx;
   logic [REF_BITS-1:0]              wr_val;
   logic [31:0]                      res_refs_wide, res_idx_wide;

   always_comb begin
      res_status = rcct_pkg::STAT_ABSENT;
      res_refs   = '0;
      res_idx    = '0;
      wr_refs    = 1'b0;
      wr_key     = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      wr_idx     = hit_idx_ff;
      wr_val     = '0;
      if (op_ff == rcct_pkg::OP_GET) begin
         priority if (hit_found_ff && refs_rd_ff == REF_MAX) begin
            res_status = rcct_pkg::STAT_OVERFLOW;
            res_refs   = refs_rd_ff;
            res_idx    = hit_idx_ff;
         end else if (hit_found_ff) begin
            res_status = rcct_pkg::STAT_HIT;
            res_refs   = refs_rd_ff + REF_ONE;
            res_idx    = hit_idx_ff;
            wr_refs    = 1'b1;
            wr_val     = refs_rd_ff + REF_ONE;
         end else if (used_w >= limit_w || !free_found_ff) begin
            res_status = rcct_pkg::STAT_FULL;
         end else begin
            res_status = rcct_pkg::STAT_MISS;
            res_refs   = REF_ONE;
            res_idx    = free_idx_ff;
            wr_idx     = free_idx_ff;
            wr_refs    = 1'b1;
            wr_key     = 1'b1;
            set_valid  = 1'b1;
            wr_val     = REF_ONE;
         end
      end else begin
         priority if (!hit_found_ff) begin
            res_status = rcct_pkg::STAT_ABSENT;
         end else if (refs_rd_ff <= REF_ONE) begin
            res_status = rcct_pkg::STAT_EVICT;
            res_idx    = hit_idx_ff;
            wr_refs    = 1'b1;
            clr_valid  = 1'b1;
         end else begin
            res_status = rcct_pkg::STAT_HELD;
            res_refs   = refs_rd_ff - REF_ONE;
            res_idx    = hit_idx_ff;
            wr_refs    = 1'b1;
            wr_val     = refs_rd_ff - REF_ONE;
         end
      end
      res_refs_wide = 32'(res_refs);
      res_idx_wide  = 32'(res_idx);
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_refs) begin
         entry_refs_ff[wr_idx] <= wr_val;
      end
      if (cmd.commit && wr_key) begin
         entry_key_ff[wr_idx] <= key_ff;
      end
   end

   // control state next values
   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      cap_in   = cap_ff;
      if (cmd.commit && set_valid) begin
         valid_in[wr_idx] = 1'b1;
         used_in          = used_ff + USED_BITS'(1);
      end
      if (cmd.commit && clr_valid) begin
         valid_in[wr_idx] = 1'b0;
         if (used_ff != '0) begin
            used_in = used_ff - USED_BITS'(1);
         end
      end
      if (csr_write) begin
         cap_in = csr_capacity_limit;
      end
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_refs_wide[rcct_pkg::COUNT_PORT_BITS-1:0];
         rsp_slot_ff   <= res_idx_wide[rcct_pkg::SLOT_PORT_BITS-1:0];
      end
   end

   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_ref_count = rsp_count_ff;
   assign rsp_slot      = rsp_slot_ff;

endmodule

`default_nettype wire

[rtl/refcounted_cache_table_unit.sv]
// an accepted request passes the lookup and update states before its result is registered;
// the update waits while the result is stalled, and no new request is taken until it commits
// (compare at accept, encode and read, then read-modify-write through the count memory)
// reset: synchronous, active high; clears valid bits, occupancy, capacity limit and
// the result valid bit; key and count storage are not cleared, no clearing pass
`default_nettype none

module refcounted_cache_table_unit #(
   parameter int ENTRIES  = rcct_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = rcct_pkg::DEF_KEY_BITS,
   parameter int REF_BITS = rcct_pkg::DEF_REF_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic [rcct_pkg::KEY_PORT_BITS-1:0]  req_key,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rcct_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [rcct_pkg::COUNT_PORT_BITS-1:0]     rsp_ref_count,
   output logic [rcct_pkg::SLOT_PORT_BITS-1:0]      rsp_slot,
   // capacity limit register write
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rcct_pkg::CAP_BITS-1:0]       csr_capacity_limit
);

   rcct_pkg::rcct_cmd_type  cmd;
   rcct_pkg::rcct_stat_type stat;

   // register writes are always taken, block is idle by contract
   assign csr_ready = 1'b1;

   // sequencer: idle -> lookup -> update, update waits for the result register
   rcct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // key compare, count read-modify-write, occupancy and result register
   rcct_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .REF_BITS (REF_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_key            (req_key),
      .csr_write          (csr_valid && csr_ready),
      .csr_capacity_limit (csr_capacity_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_ref_count      (rsp_ref_count),
      .rsp_slot           (rsp_slot)
   );

   // one transaction in flight: an accepted request is followed by a stall cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in flight");

   // an update never overwrites a stalled result
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // an update always presents a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed update produced no result");

   // a full report carries no count and no slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rcct_pkg::STAT_FULL) |->
         (rsp_ref_count == '0 && rsp_slot == '0))
      else $error("full result with nonzero count or slot");

endmodule

`default_nettype wire

[dv/tb_refcounted_cache_table_unit.sv]
// tb_refcounted_cache_table_unit: self-checking bench for the refcounted cache table
// depends on rcct_pkg and refcounted_cache_table_unit; predicts every result in-bench
`timescale 1ns / 100ps

module tb_refcounted_cache_table_unit;

   localparam int TABLE_SIZE  = rcct_pkg::DEF_ENTRIES;
   localparam int COUNT_MAX   = (1 << rcct_pkg::DEF_REF_BITS) - 1;
   localparam int KEY_W       = rcct_pkg::KEY_PORT_BITS;
   localparam int STAT_W      = rcct_pkg::STATUS_BITS;
   localparam int COUNT_W     = rcct_pkg::COUNT_PORT_BITS;
   localparam int SLOT_W      = rcct_pkg::SLOT_PORT_BITS;
   localparam int CAP_W       = rcct_pkg::CAP_BITS;
   localparam int POOL_SIZE   = 24;       // more keys than entries, so the table fills up
   localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run

   typedef struct {
      logic             op;
      logic [KEY_W-1:0] key;
      bit               hold_first;   // wait for every outstanding result first
   } request_type;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] ref_count;
      logic [SLOT_W-1:0]  slot;
   } lookup_result_type;

   // ports
   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic                req_op             = rcct_pkg::OP_GET;
   logic [KEY_W-1:0]    req_key            = '0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]  rsp_ref_count;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_capacity_limit = '0;

   // shadow copy of the cache table, advanced once per accepted request
   bit                  line_valid [TABLE_SIZE];
   logic [KEY_W-1:0]    line_key   [TABLE_SIZE];
   logic [COUNT_W-1:0]  line_refs  [TABLE_SIZE];
   int                  lines_used     = 0;
   int                  capacity_model = 0;

   request_type         pending_requests[$];
   lookup_result_type   predicted_results[$];
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   int                  n_queued      = 0;
   int                  n_accepted    = 0;
   int                  n_errors      = 0;
   int                  cycles        = 0;
   int                  send_idle_pct = 15;
   int                  stall_pct     = 64;

   refcounted_cache_table_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_ref_count      (rsp_ref_count),
      .rsp_slot           (rsp_slot),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit)
   );

   always #4 clock = ~clock;

   // lookup, then acquire or release against the shadow table
   function automatic lookup_result_type predict_access(input logic op,
                                                        input logic [KEY_W-1:0] key);
      lookup_result_type res;
      int hit_line;
      int free_line;
      int limit;
      hit_line  = -1;
      free_line = -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (line_valid[i]) begin
            if (hit_line < 0 && line_key[i] == key) hit_line = i;
         end else if (free_line < 0) begin
            free_line = i;
         end
      end
      // limit of zero or above the table size means the whole table
      limit = (capacity_model == 0 || capacity_model > TABLE_SIZE) ? TABLE_SIZE
                                                                   : capacity_model;
      if (op == rcct_pkg::OP_GET) begin
         if (hit_line >= 0) begin
            if (line_refs[hit_line] == COUNT_MAX) begin
               // saturated count stays put and is reported as is
               res = '{rcct_pkg::STAT_OVERFLOW, line_refs[hit_line], SLOT_W'(hit_line)};
            end else begin
               line_refs[hit_line] = line_refs[hit_line] + 1'b1;
               res = '{rcct_pkg::STAT_HIT, line_refs[hit_line], SLOT_W'(hit_line)};
            end
         end else if (lines_used >= limit || free_line < 0) begin
            res = '{rcct_pkg::STAT_FULL, '0, '0};
         end else begin
            // lowest free entry takes the new key
            line_valid[free_line] = 1'b1;
            line_key[free_line]   = key;
            line_refs[free_line]  = 8'd1;
            lines_used++;
            res = '{rcct_pkg::STAT_MISS, 8'd1, SLOT_W'(free_line)};
         end
      end else if (hit_line < 0) begin
         res = '{rcct_pkg::STAT_ABSENT, '0, '0};
      end else if (line_refs[hit_line] <= 1) begin
         // last reference gone, entry freed
         line_valid[hit_line] = 1'b0;
         line_refs[hit_line]  = '0;
         if (lines_used > 0) lines_used--;
         res = '{rcct_pkg::STAT_EVICT, '0, SLOT_W'(hit_line)};
      end else begin
         line_refs[hit_line] = line_refs[hit_line] - 1'b1;
         res = '{rcct_pkg::STAT_HELD, line_refs[hit_line], SLOT_W'(hit_line)};
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   task automatic add_request(input logic op, input logic [KEY_W-1:0] key,
                              input bit hold_first = 1'b0);
      pending_requests.push_back('{op, key, hold_first});
      n_queued++;
   endtask

   // mostly keys from the pool so hits, holds and evictions happen; some noise keys
   task automatic add_random_requests(input int count);
      logic             op;
      logic [KEY_W-1:0] key;
      for (int i = 0; i < count; i++) begin
         op  = ($urandom_range(99) < 52) ? rcct_pkg::OP_GET : rcct_pkg::OP_RELEASE;
         key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : $urandom();
         add_request(op, key);
      end
   endtask

   // returns once no request is queued, in flight or outstanding
   task automatic wait_until_idle();
      do @(posedge clock);
      while (n_accepted != n_queued || predicted_results.size() != 0);
   endtask

   // only called while the block is idle
   task automatic set_capacity(input int limit);
      csr_capacity_limit <= CAP_W'(limit);
      csr_valid          <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid      <= 1'b0;
      capacity_model  = limit;
   endtask

   // request driver: holds a stalled transaction, otherwise may idle or send the next one
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(predict_access(req_op, req_key));
            n_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_requests.size() != 0
                && (!pending_requests[0].hold_first || predicted_results.size() == 0)
                && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_requests.pop_front();
               req_op    <= nxt.op;
               req_key   <= nxt.key;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result monitor: every accepted transaction against the oldest prediction
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            report_mismatch("result with nothing outstanding, status", rsp_status, -1);
         end else begin
            want = predicted_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_ref_count !== want.ref_count)
               report_mismatch("ref_count", rsp_ref_count, want.ref_count);
            if (rsp_slot !== want.slot)
               report_mismatch("slot", rsp_slot, want.slot);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, predicted_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] hot_key;
      // pool starts with the all-zero, all-one and alternating keys
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'hA5A5_A5A5;
      key_pool[3] = 32'h5A5A_5A5A;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

      // sender idles a little, receiver a lot
      send_idle_pct = 15;
      stall_pct     = 64;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: capacity limit still at its reset value of zero (whole table)
      add_request(rcct_pkg::OP_GET,     key_pool[0]);   // miss into entry 0
      add_request(rcct_pkg::OP_GET,     key_pool[1]);   // miss into entry 1
      add_request(rcct_pkg::OP_GET,     key_pool[0]);   // hit
      add_request(rcct_pkg::OP_RELEASE, key_pool[0]);   // released, still held
      add_request(rcct_pkg::OP_RELEASE, key_pool[0]);   // released and evicted
      add_request(rcct_pkg::OP_RELEASE, key_pool[0]);   // release of an absent key
      add_request(rcct_pkg::OP_GET,     key_pool[2]);   // reuses the lowest free entry
      add_request(rcct_pkg::OP_RELEASE, key_pool[1]);   // evicts entry 1
      for (int i = 3; i < 18; i++) add_request(rcct_pkg::OP_GET, key_pool[i]);   // fill
      add_request(rcct_pkg::OP_GET,     key_pool[18]);  // table full
      wait_until_idle();

      // limit above the table size
      set_capacity(31);
      add_random_requests(60);
      add_request(rcct_pkg::OP_GET, key_pool[$urandom_range(POOL_SIZE - 1)], 1'b1);
      add_random_requests(60);
      wait_until_idle();

      // roles swap: sender idles a lot, receiver a little
      send_idle_pct = 64;
      stall_pct     = 15;

      // release every held reference so the table is empty
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (line_valid[i])
            repeat (line_refs[i]) add_request(rcct_pkg::OP_RELEASE, line_key[i]);
      end
      wait_until_idle();

      // single entry allowed; one key driven into count saturation and back down,
      // with gets that find the table full and releases of absent keys mixed in
      set_capacity(1);
      hot_key = $urandom();
      for (int i = 0; i < COUNT_MAX + 2; i++) begin
         add_request(rcct_pkg::OP_GET, hot_key);
         if (i % 8 == 7)
            add_request($urandom_range(1) ? rcct_pkg::OP_GET : rcct_pkg::OP_RELEASE,
                        key_pool[$urandom_range(POOL_SIZE - 1)]);
      end
      for (int i = 0; i < COUNT_MAX + 1; i++) add_request(rcct_pkg::OP_RELEASE, hot_key);
      wait_until_idle();

      set_capacity(5);
      add_random_requests(60);
      wait_until_idle();

      // limit equal to the table size
      set_capacity(16);
      add_random_requests(60);
      wait_until_idle();

      // no idling on either side, limit written back to zero
      send_idle_pct = 0;
      stall_pct     = 0;
      set_capacity(0);
      add_random_requests(90);
      wait_until_idle();

      // let any stray result show up
      repeat (10) @(posedge clock);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
